/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SWS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define SWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/sws_pkg.sv */
// Types and constants shared by the stack with statistics block.
`timescale 1ns / 1ps
package sws_pkg;

    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 7;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_POP,
        BK_SCAN,
        BK_ABS,
        BK_DIV,
        BK_FIN
    } bk_state_t;

endpackage

/* hdl/sws_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/sws_front.sv */
// Front end: takes requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module sws_front import sws_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     cmd_valid,
    output cmd_t                     cmd,
    input  logic                     cmd_take
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    op_t        op_class;
    logic       accept;
    logic       take;

    always_comb
    begin
        unique case (req_type)
            REQ_PUSH:  op_class = OP_PUSH;
            REQ_POP:   op_class = OP_POP;
            REQ_QUERY: op_class = OP_QUERY;
            default:   op_class = OP_NONE;
        endcase
    end

    assign busy      = (cnt_reg == 2'd2);
    assign accept    = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign take      = cmd_take && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_class, value: push_value};
        end
    end

endmodule

/* hdl/sws_back.sv */
// Back end: executes stack operations, scans entries for statistics and divides for the mean.
`timescale 1ns / 1ps
module sws_back import sws_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  cmd_t                         cmd,
    output logic                         cmd_take,
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [DATA_W-1:0]     pop_value,
    output logic [OUT_CNT_W-1:0]         depth,
    output logic signed [DATA_W-1:0]     max_value,
    output logic signed [DATA_W-1:0]     min_value,
    output logic signed [DATA_W-1:0]     mean_value,
    output logic [OUT_CNT_W-1:0]         odd_count,
    output logic [OUT_CNT_W-1:0]         even_count
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W = DATA_W + CW;
    localparam int BW    = $clog2(SUM_W);

    bk_state_t state_reg, state_next;

    logic [CW-1:0]              top_reg, top_next;
    logic [CW-1:0]              iss_reg, iss_next;
    logic [CW-1:0]              acc_reg, acc_next;
    logic                       dv_reg, dv_next;
    logic signed [DATA_W-1:0]   max_reg, max_next;
    logic signed [DATA_W-1:0]   min_reg, min_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [CW-1:0]              odd_reg, odd_next;
    logic [CW-1:0]              even_reg, even_next;
    logic [SUM_W-1:0]           dvd_reg, dvd_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic [BW-1:0]              bit_reg, bit_next;

    logic                       done_reg, done_next;
    logic [1:0]                 status_reg, status_next;
    logic [DATA_W-1:0]          pop_reg, pop_next;
    logic [OUT_CNT_W-1:0]       depth_reg, depth_next;
    logic [DATA_W-1:0]          rmax_reg, rmax_next;
    logic [DATA_W-1:0]          rmin_reg, rmin_next;
    logic [DATA_W-1:0]          mean_reg, mean_next;
    logic [OUT_CNT_W-1:0]       rodd_reg, rodd_next;
    logic [OUT_CNT_W-1:0]       reven_reg, reven_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [DATA_W-1:0]          ram_rdata;

    logic                       is_full;
    logic                       is_empty;
    logic [CW-1:0]              top_inc;
    logic [CW-1:0]              top_dec;
    logic                       iss_more;
    logic [CW-1:0]              acc_inc;
    logic                       scan_last;
    logic                       div_last;
    logic signed [DATA_W-1:0]   elem;
    logic [CW:0]                rem_sh;
    logic                       rem_ge;
    logic [DATA_W-1:0]          quot;

    sws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_full   = (top_reg == CW'(STACK_DEPTH));
    assign is_empty  = (top_reg == '0);
    assign top_inc   = top_reg + 1'b1;
    assign top_dec   = top_reg - 1'b1;
    assign iss_more  = (iss_reg < top_reg);
    assign acc_inc   = acc_reg + 1'b1;
    assign scan_last = dv_reg && (acc_inc == top_reg);
    assign div_last  = (bit_reg == BW'(SUM_W - 1));
    assign elem      = ram_rdata;
    assign rem_sh    = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge    = (rem_sh >= {1'b0, top_reg});
    assign quot      = dvd_reg[DATA_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_POP && !is_empty)
                    begin
                        state_next = BK_POP;
                    end
                    else if (cmd.op == OP_QUERY && !is_empty)
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_POP:  state_next = BK_IDLE;
            BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = BK_ABS;
                end
            end
            BK_ABS:  state_next = BK_DIV;
            BK_DIV:
            begin
                if (div_last)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:  state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and result outputs.
    always_comb
    begin
        cmd_take    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = top_reg[AW-1:0];
        ram_raddr   = top_dec[AW-1:0];
        top_next    = top_reg;
        iss_next    = iss_reg;
        acc_next    = acc_reg;
        dv_next     = 1'b0;
        max_next    = max_reg;
        min_next    = min_reg;
        sum_next    = sum_reg;
        odd_next    = odd_reg;
        even_next   = even_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        pop_next    = pop_reg;
        depth_next  = depth_reg;
        rmax_next   = rmax_reg;
        rmin_next   = rmin_reg;
        mean_next   = mean_reg;
        rodd_next   = rodd_reg;
        reven_next  = reven_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take    = 1'b1;
                    status_next = ST_OK;
                    pop_next    = '0;
                    depth_next  = OUT_CNT_W'(top_reg);
                    rmax_next   = '0;
                    rmin_next   = '0;
                    mean_next   = '0;
                    rodd_next   = '0;
                    reven_next  = '0;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                top_next   = top_inc;
                                depth_next = OUT_CNT_W'(top_inc);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                                pop_next    = POP_EMPTY_VALUE;
                            end
                            else
                            begin
                                top_next = top_dec;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                iss_next  = '0;
                                acc_next  = '0;
                                sum_next  = '0;
                                odd_next  = '0;
                                even_next = '0;
                            end
                        end
                        OP_NONE:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                pop_next    = ram_rdata;
                depth_next  = OUT_CNT_W'(top_reg);
                rmax_next   = '0;
                rmin_next   = '0;
                mean_next   = '0;
                rodd_next   = '0;
                reven_next  = '0;
            end
            BK_SCAN:
            begin
                // Each read is issued in the cycle before its data returns from the registered RAM.
                ram_raddr = iss_reg[AW-1:0];
                if (iss_more)
                begin
                    iss_next = iss_reg + 1'b1;
                    dv_next  = 1'b1;
                end
                if (dv_reg)
                begin
                    acc_next = acc_inc;
                    if (acc_reg == '0 || elem > max_reg)
                    begin
                        max_next = elem;
                    end
                    if (acc_reg == '0 || elem < min_reg)
                    begin
                        min_next = elem;
                    end
                    sum_next = sum_reg + {{CW{elem[DATA_W-1]}}, elem};
                    if (elem[0])
                    begin
                        odd_next = odd_reg + 1'b1;
                    end
                    else
                    begin
                        even_next = even_reg + 1'b1;
                    end
                end
            end
            BK_ABS:
            begin
                neg_next = sum_reg[SUM_W-1];
                dvd_next = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                rem_next = '0;
                bit_next = '0;
            end
            BK_DIV:
            begin
                // Restoring division, one quotient bit per cycle; the dividend
                // register fills with quotient bits from the bottom.
                rem_next = rem_ge ? CW'(rem_sh - {1'b0, top_reg}) : CW'(rem_sh);
                dvd_next = {dvd_reg[SUM_W-2:0], rem_ge};
                bit_next = bit_reg + 1'b1;
            end
            BK_FIN:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                pop_next    = '0;
                depth_next  = OUT_CNT_W'(top_reg);
                rmax_next   = max_reg;
                rmin_next   = min_reg;
                mean_next   = neg_reg ? (~quot + 1'b1) : quot;
                rodd_next   = OUT_CNT_W'(odd_reg);
                reven_next  = OUT_CNT_W'(even_reg);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            top_reg   <= '0;
            dv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            dv_reg    <= dv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_reg    <= iss_next;
        acc_reg    <= acc_next;
        max_reg    <= max_next;
        min_reg    <= min_next;
        sum_reg    <= sum_next;
        odd_reg    <= odd_next;
        even_reg   <= even_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        bit_reg    <= bit_next;
        status_reg <= status_next;
        pop_reg    <= pop_next;
        depth_reg  <= depth_next;
        rmax_reg   <= rmax_next;
        rmin_reg   <= rmin_next;
        mean_reg   <= mean_next;
        rodd_reg   <= rodd_next;
        reven_reg  <= reven_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign pop_value  = pop_reg;
    assign depth      = depth_reg;
    assign max_value  = rmax_reg;
    assign min_value  = rmin_reg;
    assign mean_value = mean_reg;
    assign odd_count  = rodd_reg;
    assign even_count = reven_reg;

endmodule

/* hdl/stack_with_statistics.sv */
// Each request passes through the request queue and the back end's registered result outputs.
// A statistics query over N stored entries takes a scan and a division:
// one RAM read per entry, then one quotient bit per cycle of the mean divider.
// A two-entry request queue keeps busy low until the back end falls two requests behind.
// The back end completes one push or rejected request per cycle; a pop also visits BK_POP.
// Reset (asynchronous, active low) empties the stack and the queue; entry data is not cleared.
`timescale 1ns / 1ps
module stack_with_statistics import sws_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_type,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [OUT_CNT_W-1:0]     depth,
    output logic signed [DATA_W-1:0] max_value,
    output logic signed [DATA_W-1:0] min_value,
    output logic signed [DATA_W-1:0] mean_value,
    output logic [OUT_CNT_W-1:0]     odd_count,
    output logic [OUT_CNT_W-1:0]     even_count
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    sws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .push_value (push_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    sws_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .done       (done),
        .status     (status),
        .pop_value  (pop_value),
        .depth      (depth),
        .max_value  (max_value),
        .min_value  (min_value),
        .mean_value (mean_value),
        .odd_count  (odd_count),
        .even_count (even_count)
    );

endmodule

/* hdl/sws_checker.sv */
// Port-level checks on the results of the stack block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sws_props import sws_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     done,
    input logic [1:0]               status,
    input logic signed [DATA_W-1:0] pop_value,
    input logic [OUT_CNT_W-1:0]     depth,
    input logic signed [DATA_W-1:0] max_value,
    input logic signed [DATA_W-1:0] min_value,
    input logic signed [DATA_W-1:0] mean_value,
    input logic [OUT_CNT_W-1:0]     odd_count,
    input logic [OUT_CNT_W-1:0]     even_count
);

    logic mean_ok;
    logic empty_res;
    logic empty_zero;
    logic full_res;
    logic full_zero;
    logic has_counts;
    logic parity_ok;

    assign mean_ok    = !done || (min_value <= mean_value && mean_value <= max_value);
    assign empty_res  = done && status == ST_EMPTY;
    assign empty_zero = depth == '0 && max_value == '0 && min_value == '0;
    assign full_res   = done && status == ST_FULL;
    assign full_zero  = pop_value == '0 && mean_value == '0;
    assign has_counts = done && (odd_count != '0 || even_count != '0);
    assign parity_ok  = (OUT_CNT_W'(odd_count + even_count) == depth);

    // The mean of the stored entries always lies between their extremes.
    `SWS_ASSERT_ALWAYS(a_mean_in_range, clk, rst_n, mean_ok)

    // An empty stack reports no entries and no statistics.
    `SWS_ASSERT_IMP(a_empty_zero, clk, rst_n, empty_res, empty_zero)

    // A dropped push returns no value.
    `SWS_ASSERT_IMP(a_full_no_value, clk, rst_n, full_res, full_zero)

    // Every scanned entry is either odd or even.
    `SWS_ASSERT_IMP(a_parity_sum, clk, rst_n, has_counts, parity_ok)

endmodule

bind stack_with_statistics sws_props u_sws_props (.*);
